[hdl/gtk_pkg.sv]
// ---------------------------------------------------------------------------
// gtk_pkg: shared types and constants of the gated track table
// Entry layout, store control, sequencer states, register codes, ln table.
// ---------------------------------------------------------------------------
package gtk_pkg;

   localparam int DIV_W   = 42;
   localparam int DVS_W   = 17;
   localparam int SCORE_W = 46;
   localparam int LN_W    = 17;
   localparam int LN2_Q12 = 2839;

   localparam logic [2:0] CSR_PROCESS_NOISE  = 3'd0;
   localparam logic [2:0] CSR_MEAS_VARIANCE  = 3'd1;
   localparam logic [2:0] CSR_INIT_VARIANCE  = 3'd2;
   localparam logic [2:0] CSR_PRUNE_VARIANCE = 3'd3;
   localparam logic [2:0] CSR_GATE_LIMIT     = 3'd4;

   localparam logic [15:0] RST_PROCESS_NOISE  = 16'd819;
   localparam logic [15:0] RST_MEAS_VARIANCE  = 16'd2621;
   localparam logic [15:0] RST_INIT_VARIANCE  = 16'd8028;
   localparam logic [15:0] RST_PRUNE_VARIANCE = 16'd16384;
   localparam logic [15:0] RST_GATE_LIMIT     = 16'd3807;

   localparam logic [11:0] LN_FRAC [32] = '{
      12'd0,    12'd126,  12'd248,  12'd367,  12'd482,  12'd595,  12'd704,  12'd810,
      12'd914,  12'd1015, 12'd1114, 12'd1210, 12'd1304, 12'd1396, 12'd1486, 12'd1575,
      12'd1661, 12'd1745, 12'd1828, 12'd1909, 12'd1989, 12'd2067, 12'd2143, 12'd2218,
      12'd2292, 12'd2365, 12'd2436, 12'd2506, 12'd2575, 12'd2642, 12'd2709, 12'd2775
   };

   typedef struct packed {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] var_x;
      logic [15:0] var_y;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic set_valid;
      logic clr_valid;
   } store_ctl_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FRD,
      ST_FUP,
      ST_DRD,
      ST_DLD,
      ST_DMUL,
      ST_DDIV,
      ST_DWAIT,
      ST_DCMP,
      ST_KRD,
      ST_KLD,
      ST_KMUL,
      ST_KDIV,
      ST_KWAIT,
      ST_KWR,
      ST_NEW,
      ST_DONE
   } state_type;

   // ln(v / 2^14) in signed Q4.12, v >= 1
   function automatic logic signed [LN_W-1:0] ln_q12(input logic [15:0] v);
      int          e;
      logic [20:0] sh;
      logic [4:0]  m;
      int          r;
      e = 0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) e = i;
      end
      sh = {v, 5'b0} >> e;
      m  = sh[4:0];
      r  = (e - 14) * LN2_Q12 + int'(LN_FRAC[m]);
      return LN_W'(r);
   endfunction

endpackage

[hdl/gtk_div.sv]
// ---------------------------------------------------------------------------
// gtk_div: shared restoring divider
// One quotient bit per cycle; done pulses when the quotient is ready.
// ---------------------------------------------------------------------------
module gtk_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [gtk_pkg::DIV_W-1:0]  dividend,
   input  logic [gtk_pkg::DVS_W-1:0]  divisor,
   output logic                       done,
   output logic [gtk_pkg::DIV_W-1:0]  quotient
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [5:0]                cnt_ff, cnt_in;
   logic [gtk_pkg::DVS_W:0]   rem_ff, rem_in;
   logic [gtk_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [gtk_pkg::DVS_W-1:0] dvs_ff, dvs_in;
   logic [gtk_pkg::DVS_W:0]   rem_sh;
   logic                      ge;

   always_comb begin
      rem_sh  = {rem_ff[gtk_pkg::DVS_W-1:0], quo_ff[gtk_pkg::DIV_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
         quo_in = {quo_ff[gtk_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(gtk_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hdl/gtk_store.sv]
// ---------------------------------------------------------------------------
// gtk_store: track table storage
// One-port-write, one-port-read entry memory with registered read, and
// per-slot valid flags.
// ---------------------------------------------------------------------------
module gtk_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gtk_pkg::store_ctl_type ctl,
   input  logic [AW-1:0]          wr_addr,
   input  gtk_pkg::entry_type     wr_data,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output gtk_pkg::entry_type     rd_data,
   output logic [DEPTH-1:0]       valid
);

   gtk_pkg::entry_type track_mem_ff [DEPTH];
   gtk_pkg::entry_type rd_data_ff;
   logic [DEPTH-1:0]   valid_ff, valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.set_valid) valid_in[wr_addr] = 1'b1;
      if (ctl.clr_valid) valid_in[wr_addr] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) track_mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= track_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign valid   = valid_ff;

endmodule

[hdl/gated_track_table_kalman.sv]
// ---------------------------------------------------------------------------
// gated_track_table_kalman: gated nearest-neighbor track table
// Keeps up to MAX_TRACKS 2-D tracks and scores, matches, updates, creates and prunes them.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: req_op 0 is a frame start (inflate the
//   variance of every valid track, prune tracks), req_op 1 is a detection at req_meas_x/y.
//   rsp_* returns exactly one result transaction per request.
//   csr_* writes the five tuning registers; write them only while idle.
// Flow (one transaction in flight; req_ready is high only when idle):
//   frame:     walks every slot, inflating and pruning each valid one.
//   detection: scores each valid slot with two divides, then runs a Kalman
//              update of the matched track, creates a track or drops it.
//   The 42-step bit-serial divider is shared by the score and the update.
// Reset clears every valid flag, the track count and the registers to
// their defaults. The result sits in an output register; a stalled
// receiver holds the block in its final state until rsp_ready.
// ---------------------------------------------------------------------------
module gated_track_table_kalman #(
   parameter int MAX_TRACKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_meas_x,
   input  logic [15:0] req_meas_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_slot,
   output logic        rsp_matched,
   output logic        rsp_created,
   output logic        rsp_dropped,
   output logic [15:0] rsp_est_x,
   output logic [15:0] rsp_est_y,
   output logic [4:0]  rsp_track_count,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CW = $clog2(MAX_TRACKS + 1);
   localparam int SW = gtk_pkg::SCORE_W;

   gtk_pkg::state_type state_ff, state_in;

   logic [15:0] pnoise_ff, pnoise_in, mvar_ff, mvar_in, ivar_ff, ivar_in;
   logic [15:0] prune_ff, prune_in, gate_ff, gate_in;

   logic [15:0] mx_ff, mx_in, my_ff, my_in;
   logic [15:0] px_ff, px_in, py_ff, py_in;
   logic [15:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [15:0] dxa_ff, dxa_in, dya_ff, dya_in;
   logic [31:0] mul_ff, mul_in;
   logic signed [SW-1:0] score_ff, score_in, best_ff, best_in;
   logic [CW-1:0] idx_ff, idx_in, count_ff, count_in;
   logic [AW-1:0] hit_ff, hit_in, free_ff, free_in;
   logic          found_ff, found_in, free_found_ff, free_found_in;
   logic          axis_ff, axis_in, step_ff, step_in;

   logic [AW-1:0] slot_ff, slot_in;
   logic          matched_ff, matched_in, created_ff, created_in;
   logic          dropped_ff, dropped_in;
   logic [15:0]   estx_ff, estx_in, esty_ff, esty_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic        rsp_matched_ff, rsp_matched_in, rsp_created_ff, rsp_created_in;
   logic        rsp_dropped_ff, rsp_dropped_in;
   logic [15:0] rsp_estx_ff, rsp_estx_in, rsp_esty_ff, rsp_esty_in;
   logic [4:0]  rsp_count_ff, rsp_count_in;

   gtk_pkg::store_ctl_type st_ctl;
   logic [AW-1:0]          st_wr_addr, st_rd_addr;
   gtk_pkg::entry_type     st_wr_data, st_rd_data;
   logic                   st_rd_en;
   logic [MAX_TRACKS-1:0]  st_valid;

   logic                          div_start, div_done;
   logic [gtk_pkg::DIV_W-1:0]     div_dividend, div_quo;
   logic [gtk_pkg::DVS_W-1:0]     div_divisor;

   logic [AW-1:0]  cur_idx;
   logic           scan_end, cur_valid;
   logic [15:0]    mul_a, mul_b;
   logic [15:0]    k_p, k_v, k_m, k_da;
   logic [16:0]    k_d, k_s, sum_a, sum_b;
   logic [15:0]    sat_a, sat_b, clx, cly;
   logic [16:0]    d_x, d_y;
   logic signed [gtk_pkg::LN_W-1:0] ln_x, ln_y;

   gtk_store #(.DEPTH(MAX_TRACKS), .AW(AW)) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (st_ctl),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data),
      .valid   (st_valid)
   );

   gtk_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      pnoise_in = pnoise_ff;
      mvar_in   = mvar_ff;
      ivar_in   = ivar_ff;
      prune_in  = prune_ff;
      gate_in   = gate_ff;
      if (csr_wr_en) begin
         case (csr_index)
            gtk_pkg::CSR_PROCESS_NOISE:  pnoise_in = csr_wdata;
            gtk_pkg::CSR_MEAS_VARIANCE:  mvar_in   = csr_wdata;
            gtk_pkg::CSR_INIT_VARIANCE:  ivar_in   = csr_wdata;
            gtk_pkg::CSR_PRUNE_VARIANCE: prune_in  = csr_wdata;
            gtk_pkg::CSR_GATE_LIMIT:     gate_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cur_idx   = idx_ff[AW-1:0];
      scan_end  = idx_ff == CW'(MAX_TRACKS);
      cur_valid = st_valid[cur_idx];

      // frame inflate
      sum_a = {1'b0, st_rd_data.var_x} + {1'b0, pnoise_ff};
      sum_b = {1'b0, st_rd_data.var_y} + {1'b0, pnoise_ff};
      sat_a = sum_a[16] ? 16'hFFFF : sum_a[15:0];
      sat_b = sum_b[16] ? 16'hFFFF : sum_b[15:0];

      // score load
      clx  = (st_rd_data.var_x == 16'd0) ? 16'd1 : st_rd_data.var_x;
      cly  = (st_rd_data.var_y == 16'd0) ? 16'd1 : st_rd_data.var_y;
      d_x  = {mx_ff[15], mx_ff} - {st_rd_data.pos_x[15], st_rd_data.pos_x};
      d_y  = {my_ff[15], my_ff} - {st_rd_data.pos_y[15], st_rd_data.pos_y};
      ln_x = gtk_pkg::ln_q12(clx);
      ln_y = gtk_pkg::ln_q12(cly);

      // Kalman axis
      k_p  = axis_ff ? py_ff : px_ff;
      k_v  = axis_ff ? vy_ff : vx_ff;
      k_m  = axis_ff ? my_ff : mx_ff;
      k_d  = {k_m[15], k_m} - {k_p[15], k_p};
      k_da = k_d[16] ? 16'(-k_d) : k_d[15:0];
      k_s  = {1'b0, k_v} + {1'b0, mvar_ff};

      state_in      = state_ff;
      mx_in         = mx_ff;
      my_in         = my_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      dxa_in        = dxa_ff;
      dya_in        = dya_ff;
      mul_in        = mul_ff;
      score_in      = score_ff;
      best_in       = best_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      hit_in        = hit_ff;
      free_in       = free_ff;
      found_in      = found_ff;
      free_found_in = free_found_ff;
      axis_in       = axis_ff;
      step_in       = step_ff;
      slot_in       = slot_ff;
      matched_in    = matched_ff;
      created_in    = created_ff;
      dropped_in    = dropped_ff;
      estx_in       = estx_ff;
      esty_in       = esty_ff;

      rsp_valid_in   = rsp_valid_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_created_in = rsp_created_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_estx_in    = rsp_estx_ff;
      rsp_esty_in    = rsp_esty_ff;
      rsp_count_in   = rsp_count_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      st_ctl       = '0;
      st_wr_addr   = cur_idx;
      st_wr_data   = st_rd_data;
      st_rd_en     = 1'b0;
      st_rd_addr   = cur_idx;
      div_start    = 1'b0;
      div_dividend = {mul_ff, 10'b0};
      div_divisor  = {1'b0, axis_ff ? vy_ff : vx_ff};
      mul_a        = axis_ff ? dya_ff : dxa_ff;
      mul_b        = mul_a;

      case (state_ff)
         gtk_pkg::ST_IDLE: begin
            if (req_valid) begin
               mx_in         = req_meas_x;
               my_in         = req_meas_y;
               idx_in        = '0;
               best_in       = {{(SW-16){gate_ff[15]}}, gate_ff};
               found_in      = 1'b0;
               free_found_in = 1'b0;
               slot_in       = '0;
               matched_in    = 1'b0;
               created_in    = 1'b0;
               dropped_in    = 1'b0;
               estx_in       = '0;
               esty_in       = '0;
               state_in      = req_op ? gtk_pkg::ST_DRD : gtk_pkg::ST_FRD;
            end
         end
         gtk_pkg::ST_FRD: begin
            if (scan_end) begin
               state_in = gtk_pkg::ST_DONE;
            end else if (!cur_valid) begin
               idx_in = idx_ff + CW'(1);
            end else begin
               st_rd_en = 1'b1;
               state_in = gtk_pkg::ST_FUP;
            end
         end
         gtk_pkg::ST_FUP: begin
            st_ctl.wr_en     = 1'b1;
            st_wr_data.var_x = sat_a;
            st_wr_data.var_y = sat_b;
            if (sat_a > prune_ff || sat_b > prune_ff) begin
               st_ctl.clr_valid = 1'b1;
               count_in         = count_ff - CW'(1);
            end
            idx_in   = idx_ff + CW'(1);
            state_in = gtk_pkg::ST_FRD;
         end
         gtk_pkg::ST_DRD: begin
            if (scan_end) begin
               if (found_ff) begin
                  state_in = gtk_pkg::ST_KRD;
               end else if (free_found_ff) begin
                  state_in = gtk_pkg::ST_NEW;
               end else begin
                  dropped_in = 1'b1;
                  state_in   = gtk_pkg::ST_DONE;
               end
            end else if (!cur_valid) begin
               if (!free_found_ff) begin
                  free_in       = cur_idx;
                  free_found_in = 1'b1;
               end
               idx_in = idx_ff + CW'(1);
            end else begin
               st_rd_en = 1'b1;
               state_in = gtk_pkg::ST_DLD;
            end
         end
         gtk_pkg::ST_DLD: begin
            vx_in    = clx;
            vy_in    = cly;
            dxa_in   = d_x[16] ? 16'(-d_x) : d_x[15:0];
            dya_in   = d_y[16] ? 16'(-d_y) : d_y[15:0];
            score_in = {{(SW-gtk_pkg::LN_W){ln_x[gtk_pkg::LN_W-1]}}, ln_x}
                     + {{(SW-gtk_pkg::LN_W){ln_y[gtk_pkg::LN_W-1]}}, ln_y};
            axis_in  = 1'b0;
            state_in = gtk_pkg::ST_DMUL;
         end
         gtk_pkg::ST_DMUL: begin
            mul_in   = mul_a * mul_b;
            state_in = gtk_pkg::ST_DDIV;
         end
         gtk_pkg::ST_DDIV: begin
            div_start = 1'b1;
            state_in  = gtk_pkg::ST_DWAIT;
         end
         gtk_pkg::ST_DWAIT: begin
            if (div_done) begin
               score_in = score_ff + $signed({{(SW-gtk_pkg::DIV_W){1'b0}}, div_quo});
               if (!axis_ff) begin
                  axis_in  = 1'b1;
                  state_in = gtk_pkg::ST_DMUL;
               end else begin
                  state_in = gtk_pkg::ST_DCMP;
               end
            end
         end
         gtk_pkg::ST_DCMP: begin
            if (score_ff < best_ff) begin
               best_in  = score_ff;
               hit_in   = cur_idx;
               found_in = 1'b1;
            end
            idx_in   = idx_ff + CW'(1);
            state_in = gtk_pkg::ST_DRD;
         end
         gtk_pkg::ST_KRD: begin
            st_rd_en   = 1'b1;
            st_rd_addr = hit_ff;
            state_in   = gtk_pkg::ST_KLD;
         end
         gtk_pkg::ST_KLD: begin
            px_in    = st_rd_data.pos_x;
            py_in    = st_rd_data.pos_y;
            vx_in    = st_rd_data.var_x;
            vy_in    = st_rd_data.var_y;
            axis_in  = 1'b0;
            step_in  = 1'b0;
            state_in = gtk_pkg::ST_KMUL;
         end
         gtk_pkg::ST_KMUL: begin
            if (k_s == 17'd0) begin
               if (!axis_ff) begin
                  axis_in = 1'b1;
               end else begin
                  state_in = gtk_pkg::ST_KWR;
               end
            end else begin
               mul_a    = step_ff ? mvar_ff : k_da;
               mul_b    = k_v;
               mul_in   = mul_a * mul_b;
               state_in = gtk_pkg::ST_KDIV;
            end
         end
         gtk_pkg::ST_KDIV: begin
            div_start    = 1'b1;
            div_dividend = gtk_pkg::DIV_W'(mul_ff) + gtk_pkg::DIV_W'(k_s >> 1);
            div_divisor  = k_s;
            state_in     = gtk_pkg::ST_KWAIT;
         end
         gtk_pkg::ST_KWAIT: begin
            div_dividend = gtk_pkg::DIV_W'(mul_ff) + gtk_pkg::DIV_W'(k_s >> 1);
            div_divisor  = k_s;
            if (div_done) begin
               if (!step_ff) begin
                  if (axis_ff) begin
                     py_in = k_d[16] ? k_p - div_quo[15:0] : k_p + div_quo[15:0];
                  end else begin
                     px_in = k_d[16] ? k_p - div_quo[15:0] : k_p + div_quo[15:0];
                  end
                  step_in  = 1'b1;
                  state_in = gtk_pkg::ST_KMUL;
               end else begin
                  if (axis_ff) begin
                     vy_in = div_quo[15:0];
                  end else begin
                     vx_in = div_quo[15:0];
                  end
                  step_in = 1'b0;
                  if (!axis_ff) begin
                     axis_in  = 1'b1;
                     state_in = gtk_pkg::ST_KMUL;
                  end else begin
                     state_in = gtk_pkg::ST_KWR;
                  end
               end
            end
         end
         gtk_pkg::ST_KWR: begin
            st_ctl.wr_en     = 1'b1;
            st_wr_addr       = hit_ff;
            st_wr_data.pos_x = px_ff;
            st_wr_data.pos_y = py_ff;
            st_wr_data.var_x = vx_ff;
            st_wr_data.var_y = vy_ff;
            slot_in          = hit_ff;
            matched_in       = 1'b1;
            estx_in          = px_ff;
            esty_in          = py_ff;
            state_in         = gtk_pkg::ST_DONE;
         end
         gtk_pkg::ST_NEW: begin
            st_ctl.wr_en     = 1'b1;
            st_ctl.set_valid = 1'b1;
            st_wr_addr       = free_ff;
            st_wr_data.pos_x = mx_ff;
            st_wr_data.pos_y = my_ff;
            st_wr_data.var_x = ivar_ff;
            st_wr_data.var_y = ivar_ff;
            count_in         = count_ff + CW'(1);
            slot_in          = free_ff;
            created_in       = 1'b1;
            estx_in          = mx_ff;
            esty_in          = my_ff;
            state_in         = gtk_pkg::ST_DONE;
         end
         gtk_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_slot_in    = 4'(slot_ff);
               rsp_matched_in = matched_ff;
               rsp_created_in = created_ff;
               rsp_dropped_in = dropped_ff;
               rsp_estx_in    = estx_ff;
               rsp_esty_in    = esty_ff;
               rsp_count_in   = 5'(count_ff);
               state_in       = gtk_pkg::ST_IDLE;
            end
         end
         default: state_in = gtk_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gtk_pkg::ST_IDLE;
         pnoise_ff    <= gtk_pkg::RST_PROCESS_NOISE;
         mvar_ff      <= gtk_pkg::RST_MEAS_VARIANCE;
         ivar_ff      <= gtk_pkg::RST_INIT_VARIANCE;
         prune_ff     <= gtk_pkg::RST_PRUNE_VARIANCE;
         gate_ff      <= gtk_pkg::RST_GATE_LIMIT;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pnoise_ff    <= pnoise_in;
         mvar_ff      <= mvar_in;
         ivar_ff      <= ivar_in;
         prune_ff     <= prune_in;
         gate_ff      <= gate_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mx_ff          <= mx_in;
      my_ff          <= my_in;
      px_ff          <= px_in;
      py_ff          <= py_in;
      vx_ff          <= vx_in;
      vy_ff          <= vy_in;
      dxa_ff         <= dxa_in;
      dya_ff         <= dya_in;
      mul_ff         <= mul_in;
      score_ff       <= score_in;
      best_ff        <= best_in;
      idx_ff         <= idx_in;
      hit_ff         <= hit_in;
      free_ff        <= free_in;
      found_ff       <= found_in;
      free_found_ff  <= free_found_in;
      axis_ff        <= axis_in;
      step_ff        <= step_in;
      slot_ff        <= slot_in;
      matched_ff     <= matched_in;
      created_ff     <= created_in;
      dropped_ff     <= dropped_in;
      estx_ff        <= estx_in;
      esty_ff        <= esty_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_created_ff <= rsp_created_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_estx_ff    <= rsp_estx_in;
      rsp_esty_ff    <= rsp_esty_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign req_ready       = state_ff == gtk_pkg::ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_created     = rsp_created_ff;
   assign rsp_dropped     = rsp_dropped_ff;
   assign rsp_est_x       = rsp_estx_ff;
   assign rsp_est_y       = rsp_esty_ff;
   assign rsp_track_count = rsp_count_ff;

endmodule

[tb/gtk_track_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gtk_track_checker: result predictor and comparator for the track table
// Watches the request, result and register channels, keeps its own model of the track table and the
// tuning registers, and compares every result transaction field by field.
// ---------------------------------------------------------------------------
module gtk_track_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_meas_x,
   input  logic [15:0] req_meas_y,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_slot,
   input  logic        rsp_matched,
   input  logic        rsp_created,
   input  logic        rsp_dropped,
   input  logic [15:0] rsp_est_x,
   input  logic [15:0] rsp_est_y,
   input  logic [4:0]  rsp_track_count,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   localparam int N_SLOTS = 16;

   typedef struct packed {
      logic [3:0]  slot;
      logic        matched;
      logic        created;
      logic        dropped;
      logic [15:0] est_x;
      logic [15:0] est_y;
      logic [4:0]  track_count;
   } outcome_type;

   localparam int LN_TAB [32] = '{
      0, 126, 248, 367, 482, 595, 704, 810, 914, 1015, 1114, 1210, 1304, 1396,
      1486, 1575, 1661, 1745, 1828, 1909, 1989, 2067, 2143, 2218, 2292, 2365,
      2436, 2506, 2575, 2642, 2709, 2775
   };

   logic [15:0]         noise_q, meas_var_q, init_var_q, prune_q;
   logic [15:0]         gate_q;
   logic                live [N_SLOTS];
   gtk_pkg::entry_type  tracks [N_SLOTS];
   outcome_type         outcome_fifo [$];

   function automatic longint log_q12(input logic [15:0] v);
      int e;
      int m;
      e = 0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) e = i;
      end
      if (e >= 5) m = (v >> (e - 5)) & 31;
      else m = (v << (5 - e)) & 31;
      return longint'(e - 14) * 2839 + LN_TAB[m];
   endfunction

   function automatic longint dist_term(input longint d, input logic [15:0] v);
      longint a;
      a = (d < 0) ? -d : d;
      return ((a * a) << 10) / longint'(v);
   endfunction

   function automatic void fuse_axis(inout logic [15:0] pos, inout logic [15:0] vr,
                                     input longint meas);
      longint v, s, p, d, a, q;
      v = longint'(vr);
      s = v + longint'(meas_var_q);
      p = longint'($signed(pos));
      d = meas - p;
      if (s == 0) return;
      a = (d < 0) ? -d : d;
      q = (a * v + s / 2) / s;
      pos = 16'((d < 0) ? p - q : p + q);
      vr = 16'((v * longint'(meas_var_q) + s / 2) / s);
   endfunction

   function automatic outcome_type track_step(input logic op, input logic [15:0] mx,
                                              input logic [15:0] my);
      outcome_type o;
      longint best, sc, a, b;
      logic [15:0] vx, vy;
      int hit, n;
      o = '0;
      hit = -1;
      if (!op) begin
         for (int i = 0; i < N_SLOTS; i++) begin
            if (!live[i]) continue;
            a = longint'(tracks[i].var_x) + noise_q;
            b = longint'(tracks[i].var_y) + noise_q;
            if (a > 65535) a = 65535;
            if (b > 65535) b = 65535;
            tracks[i].var_x = 16'(a);
            tracks[i].var_y = 16'(b);
            if (a > prune_q || b > prune_q) live[i] = 1'b0;
         end
      end else begin
         best = longint'($signed(gate_q));
         for (int i = 0; i < N_SLOTS; i++) begin
            if (!live[i]) continue;
            vx = (tracks[i].var_x == 0) ? 16'd1 : tracks[i].var_x;
            vy = (tracks[i].var_y == 0) ? 16'd1 : tracks[i].var_y;
            sc = dist_term(longint'($signed(mx)) - longint'($signed(tracks[i].pos_x)), vx)
               + dist_term(longint'($signed(my)) - longint'($signed(tracks[i].pos_y)), vy)
               + log_q12(vx) + log_q12(vy);
            if (sc < best) begin
               best = sc;
               hit = i;
            end
         end
         if (hit >= 0) begin
            fuse_axis(tracks[hit].pos_x, tracks[hit].var_x, longint'($signed(mx)));
            fuse_axis(tracks[hit].pos_y, tracks[hit].var_y, longint'($signed(my)));
            o.matched = 1'b1;
         end else begin
            for (int i = 0; i < N_SLOTS; i++) begin
               if (!live[i]) begin
                  hit = i;
                  break;
               end
            end
            if (hit >= 0) begin
               live[hit] = 1'b1;
               tracks[hit] = '{mx, my, init_var_q, init_var_q};
               o.created = 1'b1;
            end else begin
               o.dropped = 1'b1;
            end
         end
         if (hit >= 0) begin
            o.slot = 4'(hit);
            o.est_x = tracks[hit].pos_x;
            o.est_y = tracks[hit].pos_y;
         end
      end
      n = 0;
      for (int i = 0; i < N_SLOTS; i++) n += live[i];
      o.track_count = 5'(n);
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         noise_q = gtk_pkg::RST_PROCESS_NOISE;
         meas_var_q = gtk_pkg::RST_MEAS_VARIANCE;
         init_var_q = gtk_pkg::RST_INIT_VARIANCE;
         prune_q = gtk_pkg::RST_PRUNE_VARIANCE;
         gate_q = gtk_pkg::RST_GATE_LIMIT;
         for (int i = 0; i < N_SLOTS; i++) live[i] = 1'b0;
         outcome_fifo.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               gtk_pkg::CSR_PROCESS_NOISE:  noise_q = csr_wdata;
               gtk_pkg::CSR_MEAS_VARIANCE:  meas_var_q = csr_wdata;
               gtk_pkg::CSR_INIT_VARIANCE:  init_var_q = csr_wdata;
               gtk_pkg::CSR_PRUNE_VARIANCE: prune_q = csr_wdata;
               gtk_pkg::CSR_GATE_LIMIT:     gate_q = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (outcome_fifo.size() == 0) begin
               report_mismatch("unexpected transaction", 16'd1, 16'd0);
            end else begin
               want = outcome_fifo.pop_front();
               if (rsp_slot !== want.slot)
                  report_mismatch("slot", 16'(rsp_slot), 16'(want.slot));
               if (rsp_matched !== want.matched)
                  report_mismatch("matched", 16'(rsp_matched), 16'(want.matched));
               if (rsp_created !== want.created)
                  report_mismatch("created", 16'(rsp_created), 16'(want.created));
               if (rsp_dropped !== want.dropped)
                  report_mismatch("dropped", 16'(rsp_dropped), 16'(want.dropped));
               if (rsp_est_x !== want.est_x) report_mismatch("est_x", rsp_est_x, want.est_x);
               if (rsp_est_y !== want.est_y) report_mismatch("est_y", rsp_est_y, want.est_y);
               if (rsp_track_count !== want.track_count)
                  report_mismatch("track_count", 16'(rsp_track_count),
                                  16'(want.track_count));
            end
         end
         if (req_valid && req_ready)
            outcome_fifo.insert(outcome_fifo.size(),
                                track_step(req_op, req_meas_x, req_meas_y));
      end
      pending_count = outcome_fifo.size();
   end

endmodule

[tb/tb_gated_track_table_kalman.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_gated_track_table_kalman: stimulus and verdict for the track table
// Drives frames and detection clusters under several idle/stall mixes and
// register settings; a side checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_gated_track_table_kalman;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = 1'b0;
   logic [15:0] req_meas_x = '0;
   logic [15:0] req_meas_y = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_slot;
   logic        rsp_matched, rsp_created, rsp_dropped;
   logic [15:0] rsp_est_x, rsp_est_y;
   logic [4:0]  rsp_track_count;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   logic        hold_off_go = 1'b0;
   logic        hold_off_used = 1'b0;
   int          hold_off_cycles = 0;
   logic [15:0] center_x, center_y;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   gated_track_table_kalman i_dut (.*);

   gtk_track_checker i_checker (.*);

   always @(posedge clock) begin
      if (hold_off_go && !hold_off_used) begin
         hold_off_used <= 1'b1;
         hold_off_cycles <= 3000;
         rsp_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_item(input logic op, input logic [15:0] mx, input logic [15:0] my);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_op <= op;
      req_meas_x <= mx;
      req_meas_y <= my;
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // mostly clustered detections, with some frames and scattered ones, so gating and Kalman updates are reached
   task automatic tracking_burst(input int count);
      int pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_item(1'b0, 16'($urandom), 16'($urandom));
         end else if (pick < 16) begin
            send_item(1'b1, 16'($urandom), 16'($urandom));
         end else if (pick < 22) begin
            center_x = 16'($urandom);
            center_y = 16'($urandom);
            send_item(1'b1, center_x, center_y);
         end else begin
            send_item(1'b1, center_x + 16'($signed(8'($urandom))),
                      center_y + 16'($signed(8'($urandom))));
         end
      end
   endtask

   task automatic settle_regs(input logic [15:0] pn, input logic [15:0] rv,
                              input logic [15:0] iv, input logic [15:0] pv,
                              input logic [15:0] gl);
      drain_results();
      write_reg(gtk_pkg::CSR_PROCESS_NOISE, pn);
      write_reg(gtk_pkg::CSR_MEAS_VARIANCE, rv);
      write_reg(gtk_pkg::CSR_INIT_VARIANCE, iv);
      write_reg(gtk_pkg::CSR_PRUNE_VARIANCE, pv);
      write_reg(gtk_pkg::CSR_GATE_LIMIT, gl);
   endtask

   initial begin
      center_x = 16'h0100;
      center_y = 16'hff00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, ties, full table, frames on empty/full tables
      send_item(1'b0, 16'hffff, 16'hffff);
      send_item(1'b1, 16'h7fff, 16'h8000);
      send_item(1'b1, 16'h7fff, 16'h8000);
      send_item(1'b1, 16'h8000, 16'h7fff);
      send_item(1'b1, 16'h0000, 16'h0000);
      send_item(1'b1, 16'h0010, 16'hfff0);
      for (int k = 0; k < 14; k++) send_item(1'b1, 16'(k * 4096), 16'(k * 4096 + 2048));
      send_item(1'b1, 16'h4321, 16'h9abc);
      send_item(1'b0, 16'h5555, 16'haaaa);
      // zero variances and a zero update divisor
      settle_regs(16'd0, 16'd0, 16'd0, 16'hffff, 16'h7fff);
      send_item(1'b1, 16'h1234, 16'h1234);
      send_item(1'b1, 16'h1234, 16'h1235);
      send_item(1'b0, 16'h0000, 16'h0000);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: settle_regs(gtk_pkg::RST_PROCESS_NOISE, gtk_pkg::RST_MEAS_VARIANCE,
                           gtk_pkg::RST_INIT_VARIANCE, gtk_pkg::RST_PRUNE_VARIANCE,
                           gtk_pkg::RST_GATE_LIMIT);
            1: settle_regs(16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'h8000);
            2: settle_regs(16'd1, 16'd1, 16'd1, 16'hffff, 16'h7fff);
            default: settle_regs(16'($urandom_range(2000)), 16'($urandom_range(1, 65535)),
                                 16'($urandom_range(1, 20000)), 16'($urandom),
                                 16'($urandom));
         endcase
         for (int mode = 0; mode < 4; mode++) begin
            send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 58 : 35) : 0;
            stall_pct = (mode == 2) ? 58 : ((mode == 3) ? 35 : 0);
            if (ph == 0 && mode == 0) hold_off_go <= 1'b1;
            tracking_burst(95);
         end
         send_idle_pct = 0;
         stall_pct = 0;
      end
      drain_results();
      if (fail_count == 0) begin
         $display("tb_gated_track_table_kalman: done, clean");
      end else begin
         $display("tb_gated_track_table_kalman: done, errors");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("tb_gated_track_table_kalman: done, errors");
      $finish;
   end

endmodule

[sim.f]
hdl/gtk_pkg.sv
hdl/gtk_div.sv
hdl/gtk_store.sv
hdl/gated_track_table_kalman.sv
tb/gtk_track_checker.sv
tb/tb_gated_track_table_kalman.sv
